// File: rtl/sine_tone_generator_assert.svh
// Assertion macros shared by the sine tone generator RTL.
// Users must have clk_i and rst_ni in scope; define ASSERT_OFF to drop the checks.
`ifndef SINE_TONE_GENERATOR_ASSERT_SVH
`define SINE_TONE_GENERATOR_ASSERT_SVH
`ifndef ASSERT_OFF
`define STG_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("assertion failed");
`define STG_ASSERT_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error("forbidden condition seen");
`else
`define STG_ASSERT(lbl, prop)
`define STG_ASSERT_NEVER(lbl, cond)
`endif
`endif

// File: rtl/stg_pkg.sv
// Shared types, constants and functions for the sine tone generator.
// Holds the elaboration-time quarter-wave sine builder; no dependencies.
`timescale 1ns / 1ps
package stg_pkg;

  localparam int unsigned PHASE_BITS_DEF      = 32;
  localparam int unsigned TABLE_ADDR_BITS_DEF = 10;
  localparam int unsigned MAX_CHANNELS_DEF    = 8;
  localparam int unsigned OUT_LIMIT           = 8;
  localparam int unsigned QUEUE_DEPTH         = 4;

  localparam logic [31:0] PHASE_STEP_RST    = 32'h1000_0000;
  localparam logic [3:0]  CHANNEL_COUNT_RST = 4'd2;

  localparam logic [63:0] HALF_PI_Q62 = 64'h6487_ED51_10B4_611A;
  localparam logic [63:0] Q31_ONE     = 64'h8000_0000;

  typedef enum logic [1:0] {
    REG_PHASE_STEP    = 2'd0,
    REG_CHANNEL_COUNT = 2'd1,
    REG_SAMPLE_FORMAT = 2'd2
  } cfg_reg_e;

  typedef enum logic [1:0] {
    FMT_16 = 2'd0,
    FMT_24 = 2'd1,
    FMT_32 = 2'd2
  } sample_fmt_e;

  typedef struct packed {
    logic [2:0] last_chan;
    logic [1:0] sample_format;
  } back_cfg_t;

  function automatic logic [31:0] amplitude(logic [1:0] fmt);
    logic [31:0] amp;
    begin
      unique case (fmt)
        FMT_16:  amp = 32'd32767;
        FMT_24:  amp = 32'd8388607;
        default: amp = 32'd2147483647;
      endcase
      return amp;
    end
  endfunction

  function automatic logic [63:0] mul_shr(logic [63:0] a, logic [63:0] b, int unsigned s);
    logic [127:0] p;
    begin
      p = {64'd0, a} * {64'd0, b};
      p = p >> s;
      return p[63:0];
    end
  endfunction

  // Sine of k steps of (pi/2)/2^abits in Q31 through a Taylor series; used at elaboration only.
  function automatic logic [31:0] sine_q31(int unsigned k, int unsigned abits);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] sum;
    logic [63:0] r;
    int unsigned n;
    begin
      x    = mul_shr(HALF_PI_Q62, 64'(k), abits);
      x2   = mul_shr(x, x, 62);
      term = x;
      sum  = x;
      for (n = 3; n <= 25; n = n + 2) begin
        term = mul_shr(term, x2, 62) / 64'((n - 1) * n);
        if (n[1]) begin
          sum = sum - term;
        end else begin
          sum = sum + term;
        end
      end
      r = (sum + 64'h4000_0000) >> 31;
      if (r > Q31_ONE) begin
        r = Q31_ONE;
      end
      return r[31:0];
    end
  endfunction

endpackage

// File: rtl/sine_tone_generator.sv
// Sine tone generator (direct digital synthesis) top level: stream ports,
// configuration registers and the front/queue/back chain. Uses stg_pkg.
//
// Usage: every transfer on the s_axis channel requests one audio frame;
// bit 0 of s_axis_tdata set clears the phase to zero before that frame.
// The frame leaves on m_axis as one transfer per channel, all carrying the
// same signed sample in tdata, the channel position in tuser, and tlast on
// the final channel. The phase then advances by the phase step register.
// Registers are written on the cfg channel (index 0 phase step, 1 channel
// count, 2 sample format); cfg_ready_o is always high and writes to an
// unused index are dropped. Writes are meant for when the block is idle.
// A request passes the queue, the ROM read, scaling and output registers
// before its first sample is offered. Throughput is one output sample per
// cycle while m_axis_tready is high; a frame has one to eight channels.
// The output stage holds its sample while m_axis_tready is low; up to four
// frame requests then queue between front end and back end before
// s_axis_tready falls. Reset clears the phase, the pipeline and the queue,
// and loads the register defaults (step 2^28, two channels, 16 bit).
`timescale 1ns / 1ps
module sine_tone_generator #(
  parameter int unsigned PHASE_BITS      = stg_pkg::PHASE_BITS_DEF,
  parameter int unsigned TABLE_ADDR_BITS = stg_pkg::TABLE_ADDR_BITS_DEF,
  parameter int unsigned MAX_CHANNELS    = stg_pkg::MAX_CHANNELS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [0] restart_phase, [7:1] zero
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [31:0] sample_value
  output logic [2:0]  m_axis_tuser,   // [2:0] channel_index
  output logic        m_axis_tlast,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i
);

  localparam int unsigned CHAN_CAP =
    (MAX_CHANNELS < stg_pkg::OUT_LIMIT) ? MAX_CHANNELS : stg_pkg::OUT_LIMIT;
  localparam int unsigned ENTRY_W = TABLE_ADDR_BITS + 2;

  logic [31:0]        phase_step_q;
  logic [3:0]         channel_count_q;
  logic [1:0]         sample_format_q;
  logic [2:0]         last_chan;
  stg_pkg::back_cfg_t back_cfg;

  logic               push, full, pop, empty;
  logic [ENTRY_W-1:0] push_data, pop_data;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_step_q    <= stg_pkg::PHASE_STEP_RST;
      channel_count_q <= stg_pkg::CHANNEL_COUNT_RST;
      sample_format_q <= stg_pkg::FMT_16;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        stg_pkg::REG_PHASE_STEP:    phase_step_q    <= cfg_data_i;
        stg_pkg::REG_CHANNEL_COUNT: channel_count_q <= cfg_data_i[3:0];
        stg_pkg::REG_SAMPLE_FORMAT: sample_format_q <= cfg_data_i[1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (channel_count_q == 4'd0) begin
      last_chan = 3'd0;
    end else if (channel_count_q > 4'(CHAN_CAP)) begin
      last_chan = 3'(CHAN_CAP - 1);
    end else begin
      last_chan = 3'(channel_count_q - 4'd1);
    end
  end

  assign back_cfg.last_chan     = last_chan;
  assign back_cfg.sample_format = sample_format_q;

  stg_front #(
    .PHASE_BITS      (PHASE_BITS),
    .TABLE_ADDR_BITS (TABLE_ADDR_BITS)
  ) u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .req_valid_i     (s_axis_tvalid),
    .req_ready_o     (s_axis_tready),
    .restart_phase_i (s_axis_tdata[0]),
    .phase_step_i    (phase_step_q),
    .push_o          (push),
    .push_data_o     (push_data),
    .full_i          (full)
  );

  stg_fifo #(
    .WIDTH (ENTRY_W),
    .DEPTH (stg_pkg::QUEUE_DEPTH)
  ) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .full_o      (full),
    .pop_i       (pop),
    .pop_data_o  (pop_data),
    .empty_o     (empty)
  );

  stg_back #(
    .TABLE_ADDR_BITS (TABLE_ADDR_BITS)
  ) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_i           (back_cfg),
    .empty_i         (empty),
    .pop_data_i      (pop_data),
    .pop_o           (pop),
    .out_valid_o     (m_axis_tvalid),
    .out_ready_i     (m_axis_tready),
    .sample_value_o  (m_axis_tdata),
    .channel_index_o (m_axis_tuser),
    .last_of_frame_o (m_axis_tlast)
  );

endmodule

// File: rtl/stg_front.sv
// Front end: accepts frame requests, holds the phase accumulator and
// turns the phase into a quarter-table index and a sign. Uses stg_pkg.
`timescale 1ns / 1ps
module stg_front #(
  parameter int unsigned PHASE_BITS      = stg_pkg::PHASE_BITS_DEF,
  parameter int unsigned TABLE_ADDR_BITS = stg_pkg::TABLE_ADDR_BITS_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       req_valid_i,
  output logic                       req_ready_o,
  input  logic                       restart_phase_i,
  input  logic [31:0]                phase_step_i,
  output logic                       push_o,
  output logic [TABLE_ADDR_BITS+1:0] push_data_o,
  input  logic                       full_i
);

  localparam logic [TABLE_ADDR_BITS:0] FULL_TURN_IDX =
    (TABLE_ADDR_BITS + 1)'(1) << TABLE_ADDR_BITS;

  logic [PHASE_BITS-1:0]      phase_q, phase_d;
  logic [PHASE_BITS-1:0]      phase_cur;
  logic [PHASE_BITS-1:0]      step_al;
  logic [1:0]                 quad;
  logic [TABLE_ADDR_BITS-1:0] offset;
  logic [TABLE_ADDR_BITS:0]   idx;
  logic                       accept;

  if (PHASE_BITS >= 32) begin : g_step_wide
    assign step_al = PHASE_BITS'(phase_step_i) << (PHASE_BITS - 32);
  end else begin : g_step_narrow
    assign step_al = PHASE_BITS'(phase_step_i >> (32 - PHASE_BITS));
  end

  assign req_ready_o = !full_i;
  assign accept      = req_valid_i && req_ready_o;
  assign phase_cur   = restart_phase_i ? '0 : phase_q;
  assign quad        = phase_cur[PHASE_BITS-1 -: 2];
  assign offset      = phase_cur[PHASE_BITS-3 -: TABLE_ADDR_BITS];
  assign idx         = quad[0] ? (FULL_TURN_IDX - {1'b0, offset}) : {1'b0, offset};

  assign push_o      = accept;
  // The lower field is the table index, the top bit marks the negative half-turn.
  assign push_data_o = {quad[1], idx};

  always_comb begin
    phase_d = phase_q;
    if (accept) begin
      phase_d = phase_cur + step_al;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= '0;
    end else begin
      phase_q <= phase_d;
    end
  end

endmodule

// File: rtl/stg_fifo.sv
// Small register FIFO between the front end and the sample back end.
// Uses the assertion macros from sine_tone_generator_assert.svh.
`timescale 1ns / 1ps
`include "sine_tone_generator_assert.svh"
module stg_fifo #(
  parameter int unsigned WIDTH = 1,
  parameter int unsigned DEPTH = stg_pkg::QUEUE_DEPTH
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] push_data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] pop_data_o,
  output logic             empty_o
);

  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  logic [WIDTH-1:0] entry_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;

  assign full_o     = (cnt_q == CNT_FULL);
  assign empty_o    = (cnt_q == '0);
  assign pop_data_o = entry_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= push_data_i;
    end
  end

  `STG_ASSERT_NEVER(a_no_overflow, push_i && full_o)
  `STG_ASSERT_NEVER(a_no_underflow, pop_i && empty_o)
  `STG_ASSERT(a_fill_step, (push_i && !pop_i) |=> (cnt_q == $past(cnt_q) + 1'b1))

endmodule

// File: rtl/stg_back.sv
// Back end: quarter-wave ROM read, amplitude scaling, sign and the
// per-channel output register. Uses stg_pkg and the assertion macros.
`timescale 1ns / 1ps
`include "sine_tone_generator_assert.svh"
module stg_back #(
  parameter int unsigned TABLE_ADDR_BITS = stg_pkg::TABLE_ADDR_BITS_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  stg_pkg::back_cfg_t         cfg_i,
  input  logic                       empty_i,
  input  logic [TABLE_ADDR_BITS+1:0] pop_data_i,
  output logic                       pop_o,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [31:0]                sample_value_o,
  output logic [2:0]                 channel_index_o,
  output logic                       last_of_frame_o
);

  localparam int unsigned TABLE_LEN = (1 << TABLE_ADDR_BITS) + 1;

  logic [31:0] rom_tbl [TABLE_LEN];

  for (genvar g = 0; g < TABLE_LEN; g++) begin : g_rom
    localparam logic [31:0] ROM_VAL = stg_pkg::sine_q31(g, TABLE_ADDR_BITS);
    assign rom_tbl[g] = ROM_VAL;
  end

  logic        s1_valid_q, s1_neg_q;
  logic [31:0] tv_q;
  logic        s2_valid_q, s2_neg_q;
  logic [31:0] mag_q;
  logic        em_valid_q;
  logic [31:0] word_q;
  logic [2:0]  chan_q;
  logic        em_free, s2_ready, s1_ready, xfer, is_last;
  logic [63:0] prod;

  assign is_last  = (chan_q == cfg_i.last_chan);
  assign xfer     = em_valid_q && out_ready_i;
  assign em_free  = !em_valid_q || (xfer && is_last);
  assign s2_ready = !s2_valid_q || em_free;
  assign s1_ready = !s1_valid_q || s2_ready;
  assign pop_o    = !empty_i && s1_ready;
  assign prod     = {32'd0, tv_q} * {32'd0, stg_pkg::amplitude(cfg_i.sample_format)};

  assign out_valid_o     = em_valid_q;
  assign sample_value_o  = word_q;
  assign channel_index_o = chan_q;
  assign last_of_frame_o = is_last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      em_valid_q <= 1'b0;
      chan_q     <= '0;
    end else begin
      if (s1_ready) begin
        s1_valid_q <= pop_o;
      end
      if (s2_ready) begin
        s2_valid_q <= s1_valid_q;
      end
      if (em_free) begin
        em_valid_q <= s2_valid_q;
        chan_q     <= '0;
      end else if (xfer) begin
        chan_q <= chan_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      tv_q     <= rom_tbl[pop_data_i[TABLE_ADDR_BITS:0]];
      s1_neg_q <= pop_data_i[TABLE_ADDR_BITS+1];
    end
    if (s1_valid_q && s2_ready) begin
      mag_q    <= prod[62:31];
      s2_neg_q <= s1_neg_q;
    end
    if (em_free && s2_valid_q) begin
      word_q <= s2_neg_q ? (32'd0 - mag_q) : mag_q;
    end
  end

  `STG_ASSERT(a_chan_in_frame, em_valid_q |-> (chan_q <= cfg_i.last_chan))
  `STG_ASSERT(a_chan_advance, (xfer && !is_last) |=> (chan_q == $past(chan_q) + 1'b1))
  `STG_ASSERT(a_hold_on_stall, (em_valid_q && !out_ready_i) |=> (em_valid_q && $stable(word_q)))

endmodule
